[rtl/core/tcc_pkg.sv]
package tcc_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);

    // queue depth must be a power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int POS_W        = 12;
    localparam int TAB_STOPS    = 8;
    localparam int TAB_W        = $clog2(TAB_STOPS);
    localparam int SCROLL_LINES = 4;
    localparam int DIV_STEPS    = POS_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [20:0] CHAR_BACKSPACE = 21'd8;
    localparam logic [20:0] CHAR_TAB       = 21'd9;
    localparam logic [20:0] CHAR_NEWLINE   = 21'd10;
    localparam logic [20:0] CHAR_RETURN    = 21'd13;

    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEFT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_RIGHT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_TOP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_BOTTOM  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LINE_HEIGHT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_WIDTH = 3'd5;

    localparam logic [11:0] RST_WIN_LEFT    = 12'd0;
    localparam logic [11:0] RST_WIN_RIGHT   = 12'd1024;
    localparam logic [11:0] RST_WIN_TOP     = 12'd0;
    localparam logic [11:0] RST_WIN_BOTTOM  = 12'd768;
    localparam logic [7:0]  RST_LINE_HEIGHT = 8'd16;
    localparam logic [7:0]  RST_SPACE_WIDTH = 8'd8;

    typedef enum logic [2:0] {
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_BACKSPACE,
        OP_GLYPH
    } t_op;

    typedef enum logic [1:0] {
        CMD_MOVE,
        CMD_SCROLL,
        CMD_CLEAR,
        CMD_DRAW
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EXEC,
        ST_PEND
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [20:0] char_code;
        logic [7:0]  glyph_width;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_wr;

    typedef struct packed {
        t_cmd        command;
        logic [11:0] rect_x0;
        logic [11:0] rect_y0;
        logic [11:0] rect_x1;
        logic [11:0] rect_y1;
        logic [9:0]  scroll_pixels;
        logic [20:0] glyph_code;
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [11:0] win_left;
        logic [11:0] win_right;
        logic [11:0] win_top;
        logic [11:0] win_bottom;
        logic [7:0]  line_height;
        logic [7:0]  space_width;
    } t_cfg;

endpackage

[rtl/core/tcc_if.sv]
interface tcc_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] char_code;
    logic [7:0]  glyph_width;

    modport source (output valid, output char_code, output glyph_width, input ready);
    modport sink   (input valid, input char_code, input glyph_width, output ready);
endinterface

interface tcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] rect_x0;
    logic [11:0] rect_y0;
    logic [11:0] rect_x1;
    logic [11:0] rect_y1;
    logic [9:0]  scroll_pixels;
    logic [20:0] glyph_code;
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
    logic        last;

    modport source (
        output valid, output command, output rect_x0, output rect_y0,
        output rect_x1, output rect_y1, output scroll_pixels, output glyph_code,
        output cursor_x, output cursor_y, output last, input ready
    );
    modport sink (
        input valid, input command, input rect_x0, input rect_y0,
        input rect_x1, input rect_y1, input scroll_pixels, input glyph_code,
        input cursor_x, input cursor_y, input last, output ready
    );
endinterface

[rtl/core/tcc_front.sv]
module tcc_front
    import tcc_pkg::*;
(
    tcc_in_if.sink i_in,
    input  logic   i_q_full,
    output t_q_wr  o_q_wr
);

    t_op op;

    always_comb begin
        case (i_in.char_code)
            CHAR_NEWLINE:   op = OP_NEWLINE;
            CHAR_RETURN:    op = OP_RETURN;
            CHAR_TAB:       op = OP_TAB;
            CHAR_BACKSPACE: op = OP_BACKSPACE;
            default:        op = OP_GLYPH;
        endcase
    end

    assign i_in.ready              = !i_q_full;
    assign o_q_wr.push             = i_in.valid && !i_q_full;
    assign o_q_wr.item.op          = op;
    assign o_q_wr.item.char_code   = i_in.char_code;
    assign o_q_wr.item.glyph_width = i_in.glyph_width;

endmodule

[rtl/core/tcc_fifo.sv]
module tcc_fifo
    import tcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_fill, n_fill;
    logic              push, pop;

    assign o_full  = (r_fill == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_wr.push && !o_full;
    assign pop     = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr.item;
        end
    end

endmodule

[rtl/core/tcc_back.sv]
module tcc_back
    import tcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_item    i_q_item,
    input  logic     i_q_empty,
    output logic     o_q_pop,
    tcc_out_if.source o_out
);

    t_back_state           r_state, n_state;
    t_item                 r_item, n_item;
    logic [11:0]           r_cur_x, n_cur_x;
    logic [11:0]           r_cur_y, n_cur_y;
    logic [HIST_CNT_W-1:0] r_count, n_count;
    logic                  r_bs_hit, n_bs_hit;
    logic [7:0]            r_rem, n_rem;
    logic [POS_W-1:0]      r_quo, n_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    t_result               r_pend, n_pend;
    logic [11:0]           r_rd_x;

    logic [11:0]           r_hist [HISTORY_DEPTH];

    logic                  hist_we, hist_re;
    logic [HIST_IDX_W-1:0] hist_waddr, hist_raddr;
    logic [11:0]           hist_wdata;

    logic                  out_free;
    logic [HIST_CNT_W-1:0] eff_count, idx, top_idx;
    logic [8:0]            rem_sh;
    logic                  rem_ge;
    logic [9:0]            scroll_px;
    logic                  do_scroll, do_wrap;
    logic [11:0]           y_s, y_nl, base_x, base_y, tab_adv;
    logic [TAB_W:0]        tab_steps;
    t_result               res_scroll, res1, res2;
    logic                  two;

    function automatic t_result mk_move(logic [11:0] x, logic [11:0] y);
        t_result r;
        r          = '0;
        r.command  = CMD_MOVE;
        r.cursor_x = x;
        r.cursor_y = y;
        return r;
    endfunction

    assign out_free  = !r_out_valid || o_out.ready;
    // the history pointer wraps to the base once the stack is full
    assign eff_count = (r_count >= HIST_CNT_W'(HISTORY_DEPTH)) ? '0 : r_count;
    assign top_idx   = eff_count - 1'b1;

    // one restoring division step: quotient bits come out msb first
    assign rem_sh = {r_rem, r_quo[POS_W-1]};
    assign rem_ge = rem_sh >= {1'b0, i_cfg.space_width};

    assign scroll_px = 10'({2'b00, i_cfg.line_height} * 10'(SCROLL_LINES));
    assign do_scroll = ({1'b0, r_cur_y} + 13'(i_cfg.line_height)) >= {1'b0, i_cfg.win_bottom};
    assign do_wrap   = ({1'b0, r_cur_x} + 13'(r_item.glyph_width)) >= {1'b0, i_cfg.win_right};
    assign y_s       = do_scroll ? r_cur_y - 12'(scroll_px) : r_cur_y;
    assign y_nl      = y_s + 12'(i_cfg.line_height);
    assign base_x    = do_wrap ? i_cfg.win_left : r_cur_x;
    assign base_y    = do_wrap ? y_nl : r_cur_y;
    assign tab_steps = (TAB_W + 1)'(TAB_STOPS) - {1'b0, r_quo[TAB_W-1:0]};
    assign tab_adv   = 12'(tab_steps) * 12'(i_cfg.space_width);

    always_comb begin
        res_scroll               = '0;
        res_scroll.command       = CMD_SCROLL;
        res_scroll.rect_x0       = i_cfg.win_left;
        res_scroll.rect_y0       = i_cfg.win_top;
        res_scroll.rect_x1       = i_cfg.win_right;
        res_scroll.rect_y1       = i_cfg.win_bottom;
        res_scroll.scroll_pixels = scroll_px;
        res_scroll.cursor_x      = r_cur_x;
        res_scroll.cursor_y      = y_s;
    end

    // effect of the held item, applied when the output register can take it
    always_comb begin
        res1       = mk_move(r_cur_x, r_cur_y);
        res2       = mk_move(r_cur_x, r_cur_y);
        two        = 1'b0;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_count    = r_count;
        hist_we    = 1'b0;
        idx        = r_count;
        hist_wdata = r_cur_x;
        case (r_item.op)
            OP_NEWLINE: begin
                n_cur_x = i_cfg.win_left;
                n_cur_y = y_nl;
                n_count = '0;
                if (do_scroll) begin
                    two  = 1'b1;
                    res1 = res_scroll;
                    res2 = mk_move(i_cfg.win_left, y_nl);
                end else begin
                    res1 = mk_move(i_cfg.win_left, y_nl);
                end
            end
            OP_RETURN: begin
                n_cur_x = i_cfg.win_left;
                n_count = '0;
                res1    = mk_move(i_cfg.win_left, r_cur_y);
            end
            OP_TAB: begin
                hist_we = 1'b1;
                n_count = r_count + 1'b1;
                n_cur_x = r_cur_x + tab_adv;
                res1    = mk_move(r_cur_x + tab_adv, r_cur_y);
            end
            OP_BACKSPACE: begin
                if (r_bs_hit) begin
                    n_cur_x       = r_rd_x;
                    res1          = mk_move(r_rd_x, r_cur_y);
                    res1.command  = CMD_CLEAR;
                    res1.rect_x0  = r_rd_x;
                    res1.rect_y0  = r_cur_y;
                    res1.rect_x1  = r_cur_x;
                    res1.rect_y1  = r_cur_y + 12'(i_cfg.line_height);
                end
            end
            OP_GLYPH: begin
                idx        = do_wrap ? '0 : r_count;
                hist_we    = 1'b1;
                hist_wdata = base_x;
                n_count    = idx + 1'b1;
                n_cur_x    = base_x + 12'(r_item.glyph_width);
                n_cur_y    = base_y;
                res2            = mk_move(base_x + 12'(r_item.glyph_width), base_y);
                res2.command    = CMD_DRAW;
                res2.rect_x0    = base_x;
                res2.rect_y0    = base_y;
                res2.rect_x1    = base_x + 12'(r_item.glyph_width);
                res2.rect_y1    = base_y + 12'(i_cfg.line_height);
                res2.glyph_code = r_item.char_code;
                if (do_wrap && do_scroll) begin
                    two  = 1'b1;
                    res1 = res_scroll;
                end else begin
                    res1 = res2;
                end
            end
            default: begin
                res1 = mk_move(r_cur_x, r_cur_y);
            end
        endcase
        res1.last  = !two;
        res2.last  = 1'b1;
        hist_waddr = idx[HIST_IDX_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_bs_hit    = r_bs_hit;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        n_pend      = r_pend;
        o_q_pop     = 1'b0;
        hist_re     = 1'b0;
        hist_raddr  = top_idx[HIST_IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_item   = i_q_item;
                    n_bs_hit = (eff_count != '0);
                    n_state  = ST_EXEC;
                    if (i_q_item.op == OP_TAB) begin
                        n_rem     = '0;
                        n_quo     = r_cur_x - i_cfg.win_left;
                        n_div_cnt = DIV_CNT_W'(DIV_STEPS);
                        n_state   = ST_DIVIDE;
                    end else if (i_q_item.op == OP_BACKSPACE && eff_count != '0) begin
                        hist_re = 1'b1;
                    end
                end
            end
            ST_DIVIDE: begin
                n_rem     = rem_ge ? 8'(rem_sh - {1'b0, i_cfg.space_width}) : rem_sh[7:0];
                n_quo     = {r_quo[POS_W-2:0], rem_ge};
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == DIV_CNT_W'(1)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out       = res1;
                    n_out_valid = 1'b1;
                    n_pend      = res2;
                    n_state     = two ? ST_PEND : ST_IDLE;
                end
            end
            ST_PEND: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cur_x     <= RST_WIN_LEFT;
            r_cur_y     <= RST_WIN_TOP;
            r_count     <= '0;
            r_bs_hit    <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bs_hit    <= n_bs_hit;
            r_div_cnt   <= n_div_cnt;
            if (r_state == ST_IDLE && o_q_pop) begin
                r_count <= (n_bs_hit && i_q_item.op == OP_BACKSPACE) ? top_idx
                                                                      : eff_count;
            end else if (r_state == ST_EXEC && out_free) begin
                r_count <= n_count;
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (hist_we && r_state == ST_EXEC && out_free) begin
            r_hist[hist_waddr] <= hist_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_re) begin
            r_rd_x <= r_hist[hist_raddr];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.command       = r_out.command;
    assign o_out.rect_x0       = r_out.rect_x0;
    assign o_out.rect_y0       = r_out.rect_y0;
    assign o_out.rect_x1       = r_out.rect_x1;
    assign o_out.rect_y1       = r_out.rect_y1;
    assign o_out.scroll_pixels = r_out.scroll_pixels;
    assign o_out.glyph_code    = r_out.glyph_code;
    assign o_out.cursor_x      = r_out.cursor_x;
    assign o_out.cursor_y      = r_out.cursor_y;
    assign o_out.last          = r_out.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HIST_CNT_W'(HISTORY_DEPTH))
        else $error("history count beyond depth");

    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PEND && r_out_valid) |-> !r_out.last)
        else $error("first of two results marked last");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && o_q_pop) |=> (r_state != ST_IDLE))
        else $error("popped transaction not taken up");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_div_cnt != '0))
        else $error("divider running with no steps left");
`endif

endmodule

[rtl/core/text_console_cursor_engine.sv]
// Cursor engine for a bitmapped text console. Each input transaction carries one character
// and its glyph width; each gives one or two result transactions (drawing command plus the
// cursor after it), the final one flagged by last. Inputs are classified and queued (four
// entries) ahead of a sequential back end, so input is taken while results wait. The back
// end handles one character at a time, a scroll first where one is needed; a tab takes its
// stop position from a 12-step restoring divider. The backspace history is a 256-entry
// memory read into a register ahead of use. Window and font registers sit on the APB port
// and are to be written only while the block is idle; the block does not enforce this.
module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcc_in_if.sink             i_in,
    tcc_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_we;
    t_q_wr                q_wr;
    logic                 q_full, q_empty, q_pop;
    t_item                q_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_left    <= RST_WIN_LEFT;
            r_cfg.win_right   <= RST_WIN_RIGHT;
            r_cfg.win_top     <= RST_WIN_TOP;
            r_cfg.win_bottom  <= RST_WIN_BOTTOM;
            r_cfg.line_height <= RST_LINE_HEIGHT;
            r_cfg.space_width <= RST_SPACE_WIDTH;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_WIN_LEFT:    r_cfg.win_left    <= pwdata[11:0];
                REG_WIN_RIGHT:   r_cfg.win_right   <= pwdata[11:0];
                REG_WIN_TOP:     r_cfg.win_top     <= pwdata[11:0];
                REG_WIN_BOTTOM:  r_cfg.win_bottom  <= pwdata[11:0];
                REG_LINE_HEIGHT: r_cfg.line_height <= pwdata[7:0];
                REG_SPACE_WIDTH: r_cfg.space_width <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIN_LEFT:    prdata = 32'(r_cfg.win_left);
            REG_WIN_RIGHT:   prdata = 32'(r_cfg.win_right);
            REG_WIN_TOP:     prdata = 32'(r_cfg.win_top);
            REG_WIN_BOTTOM:  prdata = 32'(r_cfg.win_bottom);
            REG_LINE_HEIGHT: prdata = 32'(r_cfg.line_height);
            REG_SPACE_WIDTH: prdata = 32'(r_cfg.space_width);
            default:         prdata = '0;
        endcase
    end

    tcc_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    tcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    tcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_item  (q_item),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
